[src/abde_pkg.sv]
package abde_pkg;

  // field and accumulator widths
  localparam int unsigned InW    = 32;
  localparam int unsigned AccW   = 48;
  localparam int unsigned PairW  = 49;
  localparam int unsigned CntW   = 17;
  localparam int unsigned RatioW = 33;
  localparam int unsigned ModeW  = 2;

  typedef logic [ModeW-1:0] mode_t;

  // metric selection codes
  localparam mode_t ModeBray      = 2'd0;
  localparam mode_t ModeManhattan = 2'd1;
  localparam mode_t ModeJaccard   = 2'd2;
  localparam mode_t ModeCanberra  = 2'd3;

endpackage

[src/abundance_dissimilarity_engine_core.sv]
// Streaming dissimilarity of two abundance vectors.
// Input channel: one word per feature pair (a_value_i, b_value_i,
// last_element_i), taken when in_valid_i is high and in_stall_o is low.
// in_stall_o stays high while a word is being worked on.
// Output channel: one word (ratio_q32_o in Q1.FRACTION_BITS, manhattan_sum_o)
// per word marked last_element_i, held in an output register until taken
// with out_valid_o high and out_stall_i low. A held result does not block
// the next input words; only the final step of the next vector waits for it.
// Sequence, set by the shared radix-2 divide unit (one quotient bit a cycle):
//   pair with a equal to b: accumulate, then ready again
//   pair with a differing from b: accumulate, FRACTION_BITS divide steps and
//   the share add, or no divide when one of the two counts is zero
//   last pair adds a final select plus FRACTION_BITS divide steps, or 49 steps
//   of integer division in Canberra mode, before the result appears;
//   Manhattan mode and the empty or saturated cases skip the divide.
// The user is to write metric_mode via cfg_we_i/cfg_data_i while the block
// idles; the block does not enforce it. Reset clears the mode to Bray-Curtis,
// the output valid and all accumulators, which a registered result clears too.
module abundance_dissimilarity_engine_core #(
  parameter int unsigned COUNT_BITS    = 32,
  parameter int unsigned FRACTION_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [abde_pkg::ModeW-1:0]           cfg_data_i,
  // input words
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [abde_pkg::InW-1:0]             a_value_i,
  input  logic [abde_pkg::InW-1:0]             b_value_i,
  input  logic                                 last_element_i,
  // output words
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [abde_pkg::RatioW-1:0]          ratio_q32_o,
  output logic [abde_pkg::AccW-1:0]            manhattan_sum_o
);

  localparam int unsigned AccW   = abde_pkg::AccW;
  localparam int unsigned PairW  = abde_pkg::PairW;
  localparam int unsigned CntW   = abde_pkg::CntW;
  localparam int unsigned RatioW = abde_pkg::RatioW;
  localparam int unsigned StepW  = 6;

  localparam logic [PairW-1:0] OneQ       = PairW'(64'd1 << FRACTION_BITS);
  localparam logic [StepW-1:0] FracSteps  = StepW'(FRACTION_BITS);
  localparam logic [StepW-1:0] IntSteps   = StepW'(PairW);
  localparam logic [AccW-1:0]  AccMax     = '1;
  localparam logic [PairW-1:0] PairMax    = '1;
  localparam logic [CntW-1:0]  CntMax     = '1;

  // sequencer states
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StAcc  = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StPadd = 3'd3;
  localparam logic [2:0] StFsel = 3'd4;
  localparam logic [2:0] StFout = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [StepW-1:0]       step_q;
  logic                   div_final_q;
  abde_pkg::mode_t        mode_q;

  logic [AccW-1:0]        ads_q, min_q, max_q;
  logic [PairW-1:0]       ps_q, rs_q;
  logic [CntW-1:0]        dc_q;

  logic [COUNT_BITS-1:0]  a_q, b_q;
  logic                   last_q;
  logic [PairW-1:0]       rem_q, num_q, den_q;
  logic                   compl_q;
  logic                   out_valid_q;
  logic [RatioW-1:0]      ratio_q;
  logic [AccW-1:0]        manh_q;

  logic                   in_accept, out_free, out_load;

  // per-pair terms
  logic [COUNT_BITS-1:0]  lo, hi, diff;
  logic [COUNT_BITS:0]    pair_add;
  logic                   pair_differs;

  // saturating accumulator sums
  logic [AccW:0]          ads_sum, min_sum, max_sum;
  logic [PairW:0]         ps_sum, rs_sum;
  logic [AccW-1:0]        ads_nx, min_nx, max_nx;
  logic [PairW-1:0]       ps_nx, rs_nx;
  logic [CntW-1:0]        dc_nx;

  // divide unit
  logic [PairW:0]         rem_sh, rem_sub;
  logic                   rem_ge;
  logic [PairW-1:0]       rem_nx, num_nx;
  logic [PairW-1:0]       div_n, div_d;
  logic                   frac_sat;
  logic                   fsel_frac, fsel_int;
  logic [PairW-1:0]       res_c, res_cl;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == StFout) && out_free;

  // pair terms from the captured word
  always_comb begin
    lo = (a_q < b_q) ? a_q : b_q;
    hi = (a_q < b_q) ? b_q : a_q;
  end
  assign diff = hi - lo;
  assign pair_add = {1'b0, a_q} + {1'b0, b_q};
  assign pair_differs = (diff != '0);

  // saturating adds
  assign ads_sum = {1'b0, ads_q} + (AccW + 1)'(diff);
  assign min_sum = {1'b0, min_q} + (AccW + 1)'(lo);
  assign max_sum = {1'b0, max_q} + (AccW + 1)'(hi);
  assign ps_sum  = {1'b0, ps_q} + (PairW + 1)'(pair_add);
  assign rs_sum  = {1'b0, rs_q} + {1'b0, num_q};
  assign ads_nx = ads_sum[AccW] ? AccMax : ads_sum[AccW-1:0];
  assign min_nx = min_sum[AccW] ? AccMax : min_sum[AccW-1:0];
  assign max_nx = max_sum[AccW] ? AccMax : max_sum[AccW-1:0];
  assign ps_nx  = ps_sum[PairW] ? PairMax : ps_sum[PairW-1:0];
  assign rs_nx  = rs_sum[PairW] ? PairMax : rs_sum[PairW-1:0];
  assign dc_nx  = (dc_q == CntMax) ? CntMax : dc_q + CntW'(1);

  // one restoring divide step
  assign rem_sh  = {rem_q, num_q[PairW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign rem_nx  = rem_ge ? rem_sub[PairW-1:0] : rem_sh[PairW-1:0];
  assign num_nx  = {num_q[PairW-2:0], rem_ge};

  // fraction divide operands
  always_comb begin
    if (state_q == StAcc) begin
      div_n = PairW'(diff);
      div_d = PairW'(pair_add);
    end else if (mode_q == abde_pkg::ModeJaccard) begin
      div_n = PairW'(min_q);
      div_d = PairW'(max_q);
    end else begin
      div_n = PairW'(ads_q);
      div_d = ps_q;
    end
  end
  assign frac_sat = (div_n >= div_d);

  // final metric choice
  always_comb begin
    fsel_frac = 1'b0;
    fsel_int  = 1'b0;
    case (mode_q)
      abde_pkg::ModeBray:      fsel_frac = (ads_q != '0) && (ps_q != '0);
      abde_pkg::ModeManhattan: fsel_frac = 1'b0;
      abde_pkg::ModeJaccard:   fsel_frac = (min_q != '0) && (max_q != '0);
      abde_pkg::ModeCanberra:  fsel_int  = (dc_q != '0) && (rs_q != '0);
      default:                 fsel_frac = 1'b0;
    endcase
  end

  // result shaping: jaccard complement and clamp to one
  assign res_c  = compl_q ? (OneQ - num_q) : num_q;
  assign res_cl = (res_c > OneQ) ? OneQ : res_c;

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_accept) state_d = StAcc;
      StAcc: begin
        if (pair_differs) begin
          state_d = frac_sat ? StPadd : StDiv;
        end else begin
          state_d = last_q ? StFsel : StIdle;
        end
      end
      StDiv: begin
        if (step_q == StepW'(1)) state_d = div_final_q ? StFout : StPadd;
      end
      StPadd: state_d = last_q ? StFsel : StIdle;
      StFsel: begin
        if (fsel_int || (fsel_frac && !frac_sat)) begin
          state_d = StDiv;
        end else begin
          state_d = StFout;
        end
      end
      StFout: if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // control and accumulator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      div_final_q <= 1'b0;
      mode_q      <= abde_pkg::ModeBray;
      out_valid_q <= 1'b0;
      ads_q       <= '0;
      ps_q        <= '0;
      min_q       <= '0;
      max_q       <= '0;
      rs_q        <= '0;
      dc_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) mode_q <= cfg_data_i;
      case (state_q)
        StAcc: begin
          ads_q <= ads_nx;
          ps_q  <= ps_nx;
          min_q <= min_nx;
          max_q <= max_nx;
          if (pair_differs) begin
            dc_q        <= dc_nx;
            div_final_q <= 1'b0;
            step_q      <= FracSteps;
          end
        end
        StDiv: step_q <= step_q - StepW'(1);
        StPadd: rs_q <= rs_nx;
        StFsel: begin
          div_final_q <= 1'b1;
          step_q      <= fsel_int ? IntSteps : FracSteps;
        end
        StFout: begin
          if (out_free) begin
            ads_q <= '0;
            ps_q  <= '0;
            min_q <= '0;
            max_q <= '0;
            rs_q  <= '0;
            dc_q  <= '0;
          end
        end
        default: step_q <= step_q;
      endcase
      // output valid
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // captured word, divide datapath and output word
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_q    <= a_value_i[COUNT_BITS-1:0];
      b_q    <= b_value_i[COUNT_BITS-1:0];
      last_q <= last_element_i;
    end
    case (state_q)
      StAcc: begin
        if (frac_sat) begin
          num_q <= OneQ;
        end else begin
          rem_q <= div_n;
          num_q <= '0;
          den_q <= div_d;
        end
      end
      StDiv: begin
        rem_q <= rem_nx;
        num_q <= num_nx;
      end
      StFsel: begin
        compl_q <= (mode_q == abde_pkg::ModeJaccard) && fsel_frac;
        if (fsel_int) begin
          rem_q <= '0;
          num_q <= rs_q;
          den_q <= PairW'(dc_q);
        end else if (fsel_frac) begin
          if (frac_sat) begin
            num_q <= OneQ;
          end else begin
            rem_q <= div_n;
            num_q <= '0;
            den_q <= div_d;
          end
        end else if (mode_q == abde_pkg::ModeJaccard) begin
          num_q <= OneQ;
        end else begin
          num_q <= '0;
        end
      end
      StFout: begin
        if (out_free) begin
          ratio_q <= res_cl[RatioW-1:0];
          manh_q  <= ads_q;
        end
      end
      default: rem_q <= rem_q;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign ratio_q32_o     = ratio_q;
  assign manhattan_sum_o = manh_q;

  // remainder stays below the divisor while dividing
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (rem_q < den_q))
    else $error("divide remainder not below divisor");

  // the step counter never runs out inside a division
  a_step_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (step_q != '0))
    else $error("divide step counter empty");

  // registering a result clears the sums
  a_clear_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> ((ads_q == '0) && (dc_q == '0) && (rs_q == '0)))
    else $error("accumulators not cleared after result");

  // a ratio never exceeds one
  a_ratio_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (PairW'(ratio_q32_o) <= OneQ))
    else $error("ratio above one");

endmodule

[tb/sv/tb_abundance_dissimilarity_engine_core.sv]
module tb_abundance_dissimilarity_engine_core;

  localparam int unsigned CountBits = 32;
  localparam int unsigned FracBits  = 32;
  localparam bit [63:0] OneQ      = 64'd1 << FracBits;
  localparam bit [63:0] CountMask = (64'd1 << CountBits) - 1;
  localparam bit [63:0] AccCap    = (64'd1 << abde_pkg::AccW) - 1;
  localparam bit [63:0] PairCap   = (64'd1 << abde_pkg::PairW) - 1;
  localparam bit [63:0] CntCap    = (64'd1 << abde_pkg::CntW) - 1;
  localparam bit [abde_pkg::InW-1:0] AllOnes = '1;
  localparam int DrainCycles = 120;
  localparam int PhaseItems  = 28;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [abde_pkg::ModeW-1:0]    cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [abde_pkg::InW-1:0]      a_value_i;
  logic [abde_pkg::InW-1:0]      b_value_i;
  logic                          last_element_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [abde_pkg::RatioW-1:0]   ratio_q32_o;
  logic [abde_pkg::AccW-1:0]     manhattan_sum_o;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int idle_plan[4]   = '{0, 56, 0, 31};
  int stall_plan[4]  = '{0, 0, 56, 31};

  // running sums of the two vectors and the distances still owed by the block
  class distance_scoreboard;
    abde_pkg::mode_t metric;
    bit [63:0] diff_acc, total_acc, min_acc, max_acc, share_acc, differ_cnt;
    bit [abde_pkg::RatioW-1:0] want_ratio_q[$];
    bit [abde_pkg::AccW-1:0]   want_manh_q[$];
    int unsigned errors, pairs, distances;

    function new();
      metric = abde_pkg::ModeBray;
      errors = 0;
      pairs = 0;
      distances = 0;
      clear();
    endfunction

    function void clear();
      diff_acc = 0;
      total_acc = 0;
      min_acc = 0;
      max_acc = 0;
      share_acc = 0;
      differ_cnt = 0;
    endfunction

    function bit [63:0] clip_add(bit [63:0] acc, bit [63:0] x, bit [63:0] cap);
      if (acc >= cap || x > cap - acc) return cap;
      return acc + x;
    endfunction

    // truncated num/den in q1.f, held at 1.0 when num reaches den
    function bit [63:0] q_fraction(bit [63:0] num, bit [63:0] den);
      bit [63:0] rem, quo;
      int i;
      if (den == 0 || num >= den) return OneQ;
      rem = num;
      quo = 0;
      for (i = 0; i < FracBits; i++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= den) begin
          rem = rem - den;
          quo[0] = 1'b1;
        end
      end
      return quo;
    endfunction

    function void note_pair(bit [abde_pkg::InW-1:0] a_in, bit [abde_pkg::InW-1:0] b_in,
                            bit closes);
      bit [63:0] a, b, lo, hi, gap, ratio;
      a = a_in & CountMask;
      b = b_in & CountMask;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      gap = hi - lo;
      ratio = 0;
      pairs++;
      diff_acc  = clip_add(diff_acc, gap, AccCap);
      total_acc = clip_add(total_acc, a + b, PairCap);
      min_acc   = clip_add(min_acc, lo, AccCap);
      max_acc   = clip_add(max_acc, hi, AccCap);
      if (gap != 0) begin
        share_acc  = clip_add(share_acc, q_fraction(gap, a + b), PairCap);
        differ_cnt = clip_add(differ_cnt, 1, CntCap);
      end
      if (!closes) return;
      case (metric)
        abde_pkg::ModeBray: begin
          if (diff_acc != 0 && total_acc != 0) ratio = q_fraction(diff_acc, total_acc);
        end
        abde_pkg::ModeManhattan: ratio = 0;
        abde_pkg::ModeJaccard: begin
          if (min_acc == 0 || max_acc == 0) ratio = OneQ;
          else ratio = OneQ - q_fraction(min_acc, max_acc);
        end
        default: begin
          if (differ_cnt != 0 && share_acc != 0) begin
            ratio = share_acc / differ_cnt;
            if (ratio > OneQ) ratio = OneQ;
          end
        end
      endcase
      want_ratio_q.push_back(ratio[abde_pkg::RatioW-1:0]);
      want_manh_q.push_back(diff_acc[abde_pkg::AccW-1:0]);
      clear();
    endfunction

    function void check_distance(bit [abde_pkg::RatioW-1:0] ratio,
                                 bit [abde_pkg::AccW-1:0] manh);
      bit [abde_pkg::RatioW-1:0] r_want;
      bit [abde_pkg::AccW-1:0]   m_want;
      if (want_ratio_q.size() == 0) begin
        errors++;
        $display("%0t: distance word with none outstanding: ratio %h manhattan %h",
                 $time, ratio, manh);
        return;
      end
      r_want = want_ratio_q.pop_front();
      m_want = want_manh_q.pop_front();
      distances++;
      if (ratio !== r_want) begin
        errors++;
        $display("%0t: ratio_q32 mismatch, expected %h, got %h", $time, r_want, ratio);
      end
      if (manh !== m_want) begin
        errors++;
        $display("%0t: manhattan_sum mismatch, expected %h, got %h", $time, m_want, manh);
      end
    endfunction

    function int pending();
      return want_ratio_q.size();
    endfunction
  endclass

  distance_scoreboard sb = new();

  abundance_dissimilarity_engine_core #(
    .COUNT_BITS   (CountBits),
    .FRACTION_BITS(FracBits)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .a_value_i      (a_value_i),
    .b_value_i      (b_value_i),
    .last_element_i (last_element_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ratio_q32_o    (ratio_q32_o),
    .manhattan_sum_o(manhattan_sum_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // observe both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_pair(a_value_i, b_value_i, last_element_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_distance(ratio_q32_o, manhattan_sum_o);
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // offer one word and wait until it is taken
  task automatic send_pair(bit [abde_pkg::InW-1:0] a, bit [abde_pkg::InW-1:0] b,
                           bit closes);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    a_value_i      = a;
    b_value_i      = b;
    last_element_i = closes;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop offering, let every distance come back, then let the core go quiet
  task automatic settle();
    @(negedge clk_i) in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_metric(abde_pkg::mode_t m);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_data_i = m;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    sb.metric  = m;
  endtask

  function automatic void draw_pair(output bit [abde_pkg::InW-1:0] a,
                                    output bit [abde_pkg::InW-1:0] b);
    case ($urandom_range(0, 7))
      0, 1: begin
        a = $urandom;
        b = $urandom;
      end
      2: begin
        a = $urandom;
        b = a;
      end
      3: begin
        if ($urandom_range(0, 1)) begin
          a = 0;
          b = $urandom;
        end else begin
          a = $urandom;
          b = 0;
        end
      end
      4: begin
        a = $urandom_range(0, 15);
        b = $urandom_range(0, 15);
      end
      5: begin
        a = AllOnes - $urandom_range(0, 3);
        b = AllOnes - $urandom_range(0, 3);
      end
      6: begin
        a = $urandom;
        b = a + $urandom_range(0, 2);
      end
      default: begin
        a = $urandom_range(0, 65535);
        b = $urandom_range(0, 65535);
      end
    endcase
  endfunction

  // one vector of random pairs closed by a last word; returns its length
  task automatic send_random_vector(output int len);
    bit [abde_pkg::InW-1:0] a, b;
    int i;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
    for (i = 0; i < len; i++) begin
      draw_pair(a, b);
      send_pair(a, b, i == len - 1);
    end
  endtask

  // stimulus
  initial begin
    int p, m, items, len;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_data_i     = abde_pkg::ModeBray;
    in_valid_i     = 1'b0;
    a_value_i      = '0;
    b_value_i      = '0;
    last_element_i = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // bray-curtis from reset: empty sums, equal vectors, full disagreement
    send_pair('0, '0, 1'b1);
    send_pair(5, 5, 1'b0);
    send_pair(7, 7, 1'b1);
    send_pair('0, AllOnes, 1'b0);
    send_pair(AllOnes, '0, 1'b1);
    settle();
    write_metric(abde_pkg::ModeManhattan);
    send_pair(AllOnes, '0, 1'b0);
    send_pair(3, 10, 1'b1);
    settle();
    // jaccard: zero min sum, zero max sum, ordinary case
    write_metric(abde_pkg::ModeJaccard);
    send_pair('0, 9, 1'b1);
    send_pair('0, '0, 1'b1);
    send_pair(4, 4, 1'b0);
    send_pair(2, 6, 1'b1);
    settle();
    // canberra: no differing pair, one-sided zero, near-equal extremes
    write_metric(abde_pkg::ModeCanberra);
    send_pair(3, 3, 1'b1);
    send_pair('0, 7, 1'b0);
    send_pair(1, 3, 1'b0);
    send_pair(AllOnes, AllOnes - 1, 1'b1);
    send_pair(AllOnes, AllOnes, 1'b0);
    send_pair(1, 2, 1'b1);
    settle();

    // random vectors under each idling pattern and every metric
    for (p = 0; p < 4; p++) begin
      for (m = 0; m < 4; m++) begin
        send_idle_pct  = idle_plan[p];
        recv_stall_pct = stall_plan[p];
        write_metric(abde_pkg::mode_t'((m + p) % 4));
        if (p == 0 && m == 0) begin
          // long hold-off so that a result backs up and the input stalls
          @(posedge clk_i);
          hold_left = 600;
        end
        items = 0;
        while (items < PhaseItems) begin
          send_random_vector(len);
          items += len;
        end
        settle();
      end
    end

    $display("run covered %0d feature pairs and %0d distances over all four metrics,",
             sb.pairs, sb.distances);
    $display("with sender idling, receiver back-pressure and one long receiver hold-off");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("timeout with %0d distances outstanding", sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
